>>> hw/rtl/ntwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwa_pkg: shared types and constants
// Command and result codes, table sizing and the request record that passes
// from the front end to the back end of the neighbor table.
// ----------------------------------------------------------------------------
package ntwa_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_BEACON = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_LIST   = 2'd2;

   localparam logic [2:0] KIND_UPDATED = 3'd0;
   localparam logic [2:0] KIND_INSERTED = 3'd1;
   localparam logic [2:0] KIND_DROPPED = 3'd2;
   localparam logic [2:0] KIND_TICK    = 3'd3;
   localparam logic [2:0] KIND_LISTED  = 3'd4;
   localparam logic [2:0] KIND_EMPTY   = 3'd5;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_PERIOD  = 1'b1;

   localparam logic [31:0] TIMEOUT_RESET = 32'd100;
   localparam logic [31:0] PERIOD_RESET  = 32'd10;

   // Request as handed from the front end to the back end.
   typedef struct packed {
      logic [1:0]   cmd;
      logic [47:0]  sender_id;
      logic [191:0] motion;
      logic [79:0]  place;
   } req_type;

endpackage

>>> hw/rtl/ntwa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwa_front: request intake and queue
// Accepts requests, drops unused commands and holds the rest in a short
// queue for the back end.
// ----------------------------------------------------------------------------
module ntwa_front import ntwa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_stall,
   input  req_type       in_req,
   output logic          q_valid,
   input  logic          q_take,
   output req_type       q_req
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   req_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       fill_ff, fill_in;
   logic                 push, pop;

   // Unused command codes are accepted but never queued.
   assign in_stall = (fill_ff == PTR_W'(0) + (PTR_W+1)'(QUEUE_DEPTH));
   assign push     = in_valid && !in_stall && (in_req.cmd != 2'd3);
   assign pop      = q_take && q_valid;
   assign q_valid  = (fill_ff != '0);
   assign q_req    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> hw/rtl/ntwa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwa_back: table engine
// Holds the neighbor table, runs lookups, inserts, aging sweeps and listing,
// and drives the result register.
// ----------------------------------------------------------------------------
module ntwa_back import ntwa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_take,
   input  req_type       q_req,
   input  logic [31:0]   timeout_ticks,
   input  logic [31:0]   cleanup_period_ticks,
   output logic          out_valid,
   input  logic          out_stall,
   output logic [2:0]    out_kind,
   output logic [47:0]   out_id,
   output logic [31:0]   out_total,
   output logic [6:0]    out_removed,
   output logic          out_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LIST = 2'd2;

   logic [1:0]              state_ff, state_in;
   req_type                 cur_ff;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [47:0]             id_ff    [TABLE_DEPTH];
   logic [31:0]             stamp_ff [TABLE_DEPTH];
   logic [31:0]             count_ff [TABLE_DEPTH];
   logic [191:0]            motion_ff[TABLE_DEPTH];
   logic [79:0]             place_ff [TABLE_DEPTH];
   logic [31:0]             clock_ff, clock_in;
   logic [31:0]             countdown_ff, countdown_in;
   logic [TABLE_DEPTH-1:0]  pend_ff, pend_in;

   logic                    rv_ff, rv_in;
   logic [2:0]              rkind_ff, rkind_in;
   logic [47:0]             rid_ff, rid_in;
   logic [31:0]             rtot_ff, rtot_in;
   logic [6:0]              rrem_ff, rrem_in;
   logic                    rlast_ff, rlast_in;

   logic [TABLE_DEPTH-1:0]  hit_vec, aged_vec;
   logic                    hit_any, free_any;
   logic [SLOT_W-1:0]       hit_idx, free_idx, list_idx, wr_idx;
   logic                    wr_en;
   logic [31:0]             wr_count;
   logic [31:0]             tick_next;
   logic [CNT_W-1:0]        aged_cnt;
   logic [TABLE_DEPTH-1:0]  pend_rest;
   logic                    out_free;

   assign out_free = !rv_ff || !out_stall;
   assign tick_next = clock_ff + 32'd1;

   // Parallel compare and priority pick over the slots.
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      list_idx = '0;
      aged_cnt = '0;
      for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
         hit_vec[s]  = valid_ff[s] && (id_ff[s] == cur_ff.sender_id);
         aged_vec[s] = valid_ff[s] && ((tick_next - stamp_ff[s]) > timeout_ticks);
         if (hit_vec[s]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(s);
         end
         if (!valid_ff[s]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(s);
         end
         if (pend_ff[s]) begin
            list_idx = SLOT_W'(s);
         end
      end
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         aged_cnt = aged_cnt + CNT_W'(aged_vec[s]);
      end
      pend_rest = pend_ff & ~(TABLE_DEPTH'(1) << list_idx);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      clock_in     = clock_ff;
      countdown_in = countdown_ff;
      pend_in      = pend_ff;
      q_take       = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = hit_idx;
      wr_count     = 32'd1;
      rv_in        = rv_ff && out_stall;
      rkind_in     = rkind_ff;
      rid_in       = rid_ff;
      rtot_in      = rtot_ff;
      rrem_in      = rrem_ff;
      rlast_in     = rlast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take   = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rid_in   = '0;
               rtot_in  = '0;
               rrem_in  = '0;
               rlast_in = 1'b1;
               state_in = ST_IDLE;
               case (cur_ff.cmd)
                  CMD_BEACON: begin
                     rid_in = cur_ff.sender_id;
                     if (hit_any) begin
                        wr_en    = 1'b1;
                        wr_count = (count_ff[hit_idx] == 32'hFFFF_FFFF) ?
                                   count_ff[hit_idx] : count_ff[hit_idx] + 32'd1;
                        rkind_in = KIND_UPDATED;
                        rtot_in  = wr_count;
                     end else if (free_any) begin
                        wr_en    = 1'b1;
                        wr_idx   = free_idx;
                        valid_in[free_idx] = 1'b1;
                        rkind_in = KIND_INSERTED;
                        rtot_in  = 32'd1;
                     end else begin
                        rkind_in = KIND_DROPPED;
                     end
                  end
                  CMD_TICK: begin
                     clock_in = tick_next;
                     rkind_in = KIND_TICK;
                     if (countdown_ff <= 32'd1) begin
                        valid_in     = valid_ff & ~aged_vec;
                        rrem_in      = 7'(aged_cnt);
                        countdown_in = cleanup_period_ticks;
                     end else begin
                        countdown_in = countdown_ff - 32'd1;
                     end
                  end
                  default: begin
                     if (valid_ff == '0) begin
                        rkind_in = KIND_EMPTY;
                     end else begin
                        rv_in    = 1'b0;
                        pend_in  = valid_ff;
                        state_in = ST_LIST;
                     end
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rkind_in = KIND_LISTED;
               rid_in   = id_ff[list_idx];
               rtot_in  = count_ff[list_idx];
               rrem_in  = '0;
               rlast_in = (pend_rest == '0);
               pend_in  = pend_rest;
               if (pend_rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table payload.
   always_ff @(posedge clock) begin
      if (q_take) begin
         cur_ff <= q_req;
      end
      if (wr_en) begin
         id_ff[wr_idx]     <= cur_ff.sender_id;
         stamp_ff[wr_idx]  <= clock_ff;
         count_ff[wr_idx]  <= wr_count;
         motion_ff[wr_idx] <= cur_ff.motion;
         place_ff[wr_idx]  <= cur_ff.place;
      end
      rkind_ff <= rkind_in;
      rid_ff   <= rid_in;
      rtot_ff  <= rtot_in;
      rrem_ff  <= rrem_in;
      rlast_ff <= rlast_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         clock_ff     <= '0;
         countdown_ff <= PERIOD_RESET;
         pend_ff      <= '0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         clock_ff     <= clock_in;
         countdown_ff <= countdown_in;
         pend_ff      <= pend_in;
         rv_ff        <= rv_in;
      end
   end

   assign out_valid   = rv_ff;
   assign out_kind    = rkind_ff;
   assign out_id      = rid_ff;
   assign out_total   = rtot_ff;
   assign out_removed = rrem_ff;
   assign out_last    = rlast_ff;

endmodule

>>> hw/rtl/neighbor_table_with_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_with_aging: keyed neighbor table with periodic aging
// Top level: configuration registers, request queue and table engine.
// A beacon or tick result is registered after the request passes the
// queue and the engine's fetch and execute steps; the engine finishes one
// request before taking the next, and a list yields one response per id.
// Reset clears the table, the tick clock and the registers to defaults.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging import ntwa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_cmd,
   input  logic [47:0]   req_sender_id,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic signed [15:0] req_cell_i,
   input  logic signed [15:0] req_cell_j,
   input  logic [15:0]   req_road_number,
   input  logic signed [31:0] req_road_param,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_out_kind,
   output logic [47:0]   rsp_neighbor_id,
   output logic [31:0]   rsp_beacon_total,
   output logic [6:0]    rsp_removed_count,
   output logic          rsp_last,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [31:0]   csr_data
);

   logic [31:0] timeout_ff, period_ff;
   req_type     in_req, q_req;
   logic        q_valid, q_take;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         period_ff  <= PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_data;
            CSR_PERIOD:  period_ff  <= csr_data;
            default:     timeout_ff <= timeout_ff;
         endcase
      end
   end

   assign in_req.cmd       = req_cmd;
   assign in_req.sender_id = req_sender_id;
   assign in_req.motion    = {req_pos_x, req_pos_y, req_pos_z,
                              req_vel_x, req_vel_y, req_vel_z};
   assign in_req.place     = {req_cell_i, req_cell_j, req_road_number, req_road_param};

   ntwa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_req   (in_req),
      .q_valid  (q_valid),
      .q_take   (q_take),
      .q_req    (q_req)
   );

   ntwa_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_take               (q_take),
      .q_req                (q_req),
      .timeout_ticks        (timeout_ff),
      .cleanup_period_ticks (period_ff),
      .out_valid            (rsp_valid),
      .out_stall            (rsp_stall),
      .out_kind             (rsp_out_kind),
      .out_id               (rsp_neighbor_id),
      .out_total            (rsp_beacon_total),
      .out_removed          (rsp_removed_count),
      .out_last             (rsp_last)
   );

endmodule

>>> tb/neighbor_table_with_aging_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_tb: self-checking bench for the neighbor table
// Drives beacon, tick and list requests with random gaps and output stalls.
// A behavioral copy of the table predicts every response, and each response
// is checked field by field in order. The aging registers are changed
// between phases while the table is idle.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_tb;
   import ntwa_pkg::*;

   typedef struct {
      logic [2:0]  kind;
      logic [47:0] id;
      logic [31:0] total;
      logic [6:0]  removed;
      logic        last;
   } neighbor_rsp_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_cmd;
   logic [47:0] req_sender_id;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [31:0] req_vel_x, req_vel_y, req_vel_z;
   logic signed [15:0] req_cell_i, req_cell_j;
   logic [15:0] req_road_number;
   logic signed [31:0] req_road_param;
   logic rsp_valid, rsp_stall;
   logic [2:0] rsp_out_kind;
   logic [47:0] rsp_neighbor_id;
   logic [31:0] rsp_beacon_total;
   logic [6:0] rsp_removed_count;
   logic rsp_last;
   logic csr_valid, csr_ready, csr_index;
   logic [31:0] csr_data;

   // Shadow copy of the table and its registers.
   logic        nb_valid [TABLE_DEPTH];
   logic [47:0] nb_id [TABLE_DEPTH];
   logic [31:0] nb_stamp [TABLE_DEPTH];
   logic [31:0] nb_count [TABLE_DEPTH];
   logic [31:0] nb_clock, nb_countdown, nb_timeout, nb_period;

   neighbor_rsp_type pending_rsp[$];
   int mismatches, rsp_seen, requests_sent, removals_seen, drops_seen;
   bit calm;
   int stall_left;
   logic [47:0] id_pool [24];

   neighbor_table_with_aging uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("neighbor_table_with_aging: mismatch");
      $finish;
   end

   function automatic void push_rsp(logic [2:0] k, logic [47:0] id, logic [31:0] t,
                                    logic [6:0] r, logic l);
      neighbor_rsp_type e;
      e.kind = k; e.id = id; e.total = t; e.removed = r; e.last = l;
      pending_rsp.push_back(e);
   endfunction

   // Work out the responses of one accepted request and update the shadow table.
   function automatic void predict_neighbors(logic [1:0] cmd, logic [47:0] id);
      int hit, free_slot, last_slot;
      logic [6:0] gone;
      hit = -1; free_slot = -1; last_slot = -1; gone = '0;
      case (cmd)
         CMD_BEACON: begin
            for (int s = 0; s < TABLE_DEPTH; s++) begin
               if (nb_valid[s]) begin
                  if (hit < 0 && nb_id[s] == id) hit = s;
               end else if (free_slot < 0) begin
                  free_slot = s;
               end
            end
            if (hit >= 0) begin
               nb_stamp[hit] = nb_clock;
               if (nb_count[hit] != 32'hFFFF_FFFF) nb_count[hit]++;
               push_rsp(KIND_UPDATED, id, nb_count[hit], '0, 1'b1);
            end else if (free_slot >= 0) begin
               nb_valid[free_slot] = 1'b1;
               nb_id[free_slot] = id;
               nb_count[free_slot] = 32'd1;
               nb_stamp[free_slot] = nb_clock;
               push_rsp(KIND_INSERTED, id, 32'd1, '0, 1'b1);
            end else begin
               push_rsp(KIND_DROPPED, id, '0, '0, 1'b1);
            end
         end
         CMD_TICK: begin
            nb_clock++;
            if (nb_countdown <= 32'd1) begin
               for (int s = 0; s < TABLE_DEPTH; s++)
                  if (nb_valid[s] && (nb_clock - nb_stamp[s]) > nb_timeout) begin
                     nb_valid[s] = 1'b0;
                     gone++;
                  end
               nb_countdown = nb_period;
            end else begin
               nb_countdown--;
            end
            push_rsp(KIND_TICK, '0, '0, gone, 1'b1);
         end
         CMD_LIST: begin
            for (int s = 0; s < TABLE_DEPTH; s++)
               if (nb_valid[s]) last_slot = s;
            if (last_slot < 0)
               push_rsp(KIND_EMPTY, '0, '0, '0, 1'b1);
            for (int s = 0; s < TABLE_DEPTH; s++)
               if (nb_valid[s])
                  push_rsp(KIND_LISTED, nb_id[s], nb_count[s], '0, s == last_slot);
         end
         default: ;
      endcase
   endfunction

   // Mostly short gaps, some long ones, none while calm.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Send one request; style 0 random payload, 1 all zero, 2 all ones.
   task automatic send_request(logic [1:0] cmd, logic [47:0] id, int style = 0);
      int gap;
      logic [31:0] w [7];
      logic [15:0] h [3];
      for (int i = 0; i < 7; i++)
         w[i] = (style == 1) ? '0 : (style == 2) ? '1 : $urandom;
      for (int i = 0; i < 3; i++)
         h[i] = (style == 1) ? '0 : (style == 2) ? '1 : $urandom;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sender_id <= id;
      req_pos_x <= w[0]; req_pos_y <= w[1]; req_pos_z <= w[2];
      req_vel_x <= w[3]; req_vel_y <= w[4]; req_vel_z <= w[5];
      req_road_param <= w[6];
      req_cell_i <= h[0]; req_cell_j <= h[1]; req_road_number <= h[2];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_neighbors(cmd, id);
      requests_sent++;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until the table has answered everything.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_TIMEOUT) nb_timeout = value;
      else nb_period = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response checker with random output stalls.
   always @(posedge clock) begin
      neighbor_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response kind %0d id %h", rsp_out_kind, rsp_neighbor_id);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_out_kind == KIND_TICK) removals_seen += rsp_removed_count;
            if (rsp_out_kind == KIND_DROPPED) drops_seen++;
            if (rsp_out_kind !== e.kind || rsp_neighbor_id !== e.id ||
                rsp_beacon_total !== e.total || rsp_removed_count !== e.removed ||
                rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected kind %0d id %h total %0d removed %0d last %0b, got kind %0d id %h total %0d removed %0d last %0b",
                           rsp_seen, e.kind, e.id, e.total, e.removed, e.last,
                           rsp_out_kind, rsp_neighbor_id, rsp_beacon_total,
                           rsp_removed_count, rsp_last);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (!calm) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: stall_left = $urandom_range(1, 3);
            5: stall_left = $urandom_range(15, 40);
            default: stall_left = 0;
         endcase
      end
      rsp_stall <= (stall_left > 0);
   end

   task automatic test_empty_table();
      send_request(CMD_LIST, '0);
      send_request(CMD_TICK, '0);
      send_request(2'd3, 48'h1234);
      drain();
   endtask

   // Extreme ids and payloads, a repeated sender and the unused command.
   task automatic test_beacon_extremes();
      send_request(CMD_BEACON, '0, 1);
      send_request(CMD_BEACON, '1, 2);
      send_request(CMD_BEACON, '1, 1);
      send_request(CMD_BEACON, 48'hA5A5_5A5A_0F0F);
      send_request(CMD_BEACON, '0, 2);
      send_request(2'd3, '1, 2);
      send_request(CMD_LIST, '0);
      drain();
   endtask

   // Fill every slot, overflow the full table, then age everything out.
   task automatic test_table_full();
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_request(CMD_BEACON, 48'h0200_0000_0000 + i);
      send_request(CMD_BEACON, 48'h0300_0000_0001);
      send_request(CMD_LIST, '0);
      drain();
      write_csr(CSR_TIMEOUT, 32'd1);
      write_csr(CSR_PERIOD, 32'd1);
      repeat (14) send_request(CMD_TICK, '0);
      send_request(CMD_LIST, '0);
      drain();
   endtask

   // Random traffic over a small pool of senders, in phases of new settings.
   task automatic test_random_traffic();
      logic [47:0] id;
      for (int i = 0; i < 24; i++) id_pool[i] = {16'($urandom), 32'($urandom)};
      for (int ph = 0; ph < 7; ph++) begin
         calm = (ph == 3);
         write_csr(CSR_TIMEOUT, $urandom_range(1, 25));
         write_csr(CSR_PERIOD, $urandom_range(1, 5));
         for (int n = 0; n < 50; n++) begin
            id = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                             : id_pool[$urandom_range(0, 23)];
            case ($urandom_range(0, 99)) inside
               [0:54]:  send_request(CMD_BEACON, id);
               [55:84]: send_request(CMD_TICK, id);
               [85:96]: send_request(CMD_LIST, id);
               default: send_request(2'd3, id);
            endcase
         end
         drain();
      end
      calm = 0;
   endtask

   // Largest timeout and sweep period; kept last since the countdown reloads huge.
   task automatic test_config_extremes();
      write_csr(CSR_TIMEOUT, 32'hFFFF_FFFF);
      write_csr(CSR_PERIOD, 32'd1);
      send_request(CMD_BEACON, 48'h0400_0000_0001);
      repeat (4) send_request(CMD_TICK, '0);
      drain();
      write_csr(CSR_TIMEOUT, 32'd0 + 32'd1);
      write_csr(CSR_PERIOD, 32'hFFFF_FFFF);
      repeat (5) send_request(CMD_TICK, '0);
      send_request(CMD_LIST, '0);
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_BEACON;
      req_sender_id <= '0;
      req_pos_x <= '0; req_pos_y <= '0; req_pos_z <= '0;
      req_vel_x <= '0; req_vel_y <= '0; req_vel_z <= '0;
      req_cell_i <= '0; req_cell_j <= '0; req_road_number <= '0;
      req_road_param <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_TIMEOUT;
      csr_data <= '0;
      calm = 0; stall_left = 0;
      mismatches = 0; rsp_seen = 0; requests_sent = 0; removals_seen = 0; drops_seen = 0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         nb_valid[s] = 1'b0; nb_id[s] = '0; nb_stamp[s] = '0; nb_count[s] = '0;
      end
      nb_clock = '0;
      nb_timeout = TIMEOUT_RESET;
      nb_period = PERIOD_RESET;
      nb_countdown = PERIOD_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_beacon_extremes();
      test_table_full();
      test_random_traffic();
      test_config_extremes();

      repeat (20) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         mismatches++;
         $display("%0d expected responses never arrived", pending_rsp.size());
      end
      $display("Sent %0d requests and checked %0d responses.", requests_sent, rsp_seen);
      $display("Aging removed %0d entries; %0d beacons were dropped on a full table.",
               removals_seen, drops_seen);
      if (mismatches == 0) begin
         $display("neighbor_table_with_aging: match");
      end else begin
         $display("neighbor_table_with_aging: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ntwa_pkg.sv
hw/rtl/ntwa_front.sv
hw/rtl/ntwa_back.sv
hw/rtl/neighbor_table_with_aging.sv
tb/neighbor_table_with_aging_tb.sv
